/* hdl/gdda_pkg.sv */
// ----------------------------------------------------------------------------
// gdda_pkg
// Shared types, codes and calendar helpers for the date day arithmetic block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gdda_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 16;
  localparam int ACC_W   = 18;

  localparam logic [YEAR_W-1:0]  YEAR_MAX       = 14'd16383;
  localparam logic [YEAR_W-1:0]  MIN_YEAR_RESET = 14'd1601;
  localparam logic [YEAR_W-1:0]  CYCLE_YEARS    = 14'd400;
  localparam logic [MONTH_W-1:0] MONTH_JAN      = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB      = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC      = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST      = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_LAST_DEC   = 5'd31;

  typedef enum logic [1:0] {
    CMD_NEXT = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_SUB  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_SAT     = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic reduce;
    logic init;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic reduced;
    logic op_done;
  } dp_stat_t;

  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      4'd4:      len = 5'd30;
      4'd6:      len = 5'd30;
      4'd9:      len = 5'd30;
      4'd11:     len = 5'd30;
      default:   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

/* hdl/gregorian_date_day_arithmetic.sv */
// ----------------------------------------------------------------------------
// gregorian_date_day_arithmetic
// Next day, add days or subtract days on a Gregorian date, with validation.
// ----------------------------------------------------------------------------
// From start to done the sequencer reduces the year modulo 400, validates the date and then
//   steps one month at a time; the number of months stepped sets how long a transaction takes.
// Throughput: one transaction at a time; start is taken when busy is low.
// The result register holds a finished transaction while the next is accepted.
// done pulses for one cycle with the result; the receiver cannot stall.
// Synchronous active-high reset: sequencer idle, done low, min_year = 1601.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_day_arithmetic
  import gdda_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [YEAR_W-1:0]  cfg_wr_data,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         cmd,
  input  wire logic [YEAR_W-1:0]  in_year,
  input  wire logic [MONTH_W-1:0] in_month,
  input  wire logic [DAY_W-1:0]   in_day,
  input  wire logic [COUNT_W-1:0] day_count,
  output logic                    done,
  output logic [YEAR_W-1:0]       out_year,
  output logic [MONTH_W-1:0]      out_month,
  output logic [DAY_W-1:0]        out_day,
  output logic [1:0]              status
);

  ctrl_cmd_t ctl;
  dp_stat_t  dps;

  gdda_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (dps),
    .cmd   (ctl),
    .busy  (busy)
  );

  gdda_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (ctl),
    .stat        (dps),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_cmd      (cmd),
    .in_year     (in_year),
    .in_month    (in_month),
    .in_day      (in_day),
    .day_count   (day_count),
    .out_year    (out_year),
    .out_month   (out_month),
    .out_day     (out_day),
    .status      (status),
    .done        (done)
  );

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status != ST_UNUSED))
    else $error("unused status code on result");

  a_ok_date: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_OK)) |->
      ((out_month >= MONTH_JAN) && (out_month <= MONTH_DEC) && (out_day != 5'd0)))
    else $error("ok result with out-of-range month or day");
`endif

endmodule

`default_nettype wire

/* hdl/gdda_ctrl.sv */
// ----------------------------------------------------------------------------
// gdda_ctrl
// Sequencer: load, reduce year modulo 400, validate, step months, finish.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gdda_ctrl
  import gdda_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire dp_stat_t  stat,
  output ctrl_cmd_t      cmd,
  output logic           busy
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REDUCE = 5'b00010,
    S_INIT   = 5'b00100,
    S_STEP   = 5'b01000,
    S_SPARE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (stat.reduced) begin
          state_next = S_INIT;
        end else begin
          cmd.reduce = 1'b1;
        end
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        if (stat.op_done) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

/* hdl/gdda_dp.sv */
// ----------------------------------------------------------------------------
// gdda_dp
// Datapath: date registers, year-in-cycle counter, month stepper, result regs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gdda_dp
  import gdda_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ctrl_cmd_t          cmd,
  output dp_stat_t                stat,
  input  wire logic               cfg_wr_en,
  input  wire logic [YEAR_W-1:0]  cfg_wr_data,
  input  wire logic [1:0]         in_cmd,
  input  wire logic [YEAR_W-1:0]  in_year,
  input  wire logic [MONTH_W-1:0] in_month,
  input  wire logic [DAY_W-1:0]   in_day,
  input  wire logic [COUNT_W-1:0] day_count,
  output logic [YEAR_W-1:0]       out_year,
  output logic [MONTH_W-1:0]      out_month,
  output logic [DAY_W-1:0]        out_day,
  output logic [1:0]              status,
  output logic                    done
);

  logic [YEAR_W-1:0]    min_year;
  cmd_t                 op;
  logic [YEAR_W-1:0]    year;
  logic [MONTH_W-1:0]   month;
  logic [DAY_W-1:0]     day_in;
  logic [COUNT_W-1:0]   count;
  logic signed [ACC_W-1:0] day;
  logic [YEAR_W-1:0]    cyc;
  status_t              st;

  logic                 leap;
  logic [DAY_W-1:0]     dim;
  logic [DAY_W-1:0]     dim_prev;
  logic [MONTH_W-1:0]   month_prev;
  logic signed [ACC_W-1:0] dim_ext;
  logic signed [ACC_W-1:0] dim_prev_ext;
  logic signed [ACC_W-1:0] d_ext;
  logic signed [ACC_W-1:0] n_ext;
  logic                 invalid;
  logic                 adding;
  logic [YEAR_W-1:0]    cyc_inc;
  logic [YEAR_W-1:0]    cyc_dec;

  always_comb begin
    leap = (cyc[1:0] == 2'b00) && (cyc != 14'd100) && (cyc != 14'd200) && (cyc != 14'd300);
    dim        = days_in(month, leap);
    month_prev = (month == MONTH_JAN) ? MONTH_DEC : month - 4'd1;
    dim_prev   = days_in(month_prev, leap);
    dim_ext      = $signed({{(ACC_W-DAY_W){1'b0}}, dim});
    dim_prev_ext = $signed({{(ACC_W-DAY_W){1'b0}}, dim_prev});
    d_ext        = $signed({{(ACC_W-DAY_W){1'b0}}, day_in});
    n_ext        = $signed({{(ACC_W-COUNT_W){1'b0}}, count});
    invalid = (year < min_year) || (month < MONTH_JAN) || (month > MONTH_DEC) ||
              (day_in < DAY_FIRST) || (day_in > dim);
    adding  = (op == CMD_NEXT) || (op == CMD_ADD);
    cyc_inc = (cyc == CYCLE_YEARS - 14'd1) ? '0 : cyc + 14'd1;
    cyc_dec = (cyc == '0) ? CYCLE_YEARS - 14'd1 : cyc - 14'd1;
    stat.reduced = (cyc < CYCLE_YEARS);
    stat.op_done = (st != ST_OK) || (op == CMD_NOP) ||
                   (adding && (day <= dim_ext)) ||
                   ((op == CMD_SUB) && (day >= $signed(18'sd1)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_year <= MIN_YEAR_RESET;
    end else if (cfg_wr_en) begin
      min_year <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= cmd_t'(in_cmd);
      year   <= in_year;
      month  <= in_month;
      day_in <= in_day;
      count  <= day_count;
      cyc    <= in_year;
    end else if (cmd.reduce) begin
      cyc <= cyc - CYCLE_YEARS;
    end else if (cmd.init) begin
      if (invalid) begin
        st  <= ST_INVALID;
        day <= d_ext;
      end else begin
        st <= ST_OK;
        case (op)
          CMD_NEXT: day <= d_ext + $signed(18'sd1);
          CMD_ADD:  day <= d_ext + n_ext;
          CMD_SUB:  day <= d_ext - n_ext;
          default:  day <= d_ext;
        endcase
      end
    end else if (cmd.step) begin
      if (adding) begin
        if (month == MONTH_DEC) begin
          if (year >= YEAR_MAX) begin
            year  <= YEAR_MAX;
            month <= MONTH_DEC;
            day   <= $signed({{(ACC_W-DAY_W){1'b0}}, DAY_LAST_DEC});
            st    <= ST_SAT;
          end else begin
            year  <= year + 14'd1;
            cyc   <= cyc_inc;
            month <= MONTH_JAN;
            day   <= day - dim_ext;
          end
        end else begin
          month <= month + 4'd1;
          day   <= day - dim_ext;
        end
      end else begin
        if (month == MONTH_JAN) begin
          if (year <= min_year) begin
            year  <= min_year;
            month <= MONTH_JAN;
            day   <= $signed({{(ACC_W-DAY_W){1'b0}}, DAY_FIRST});
            st    <= ST_SAT;
          end else begin
            year  <= year - 14'd1;
            cyc   <= cyc_dec;
            month <= MONTH_DEC;
            day   <= day + dim_prev_ext;
          end
        end else begin
          month <= month_prev;
          day   <= day + dim_prev_ext;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_year  <= year;
      out_month <= month;
      out_day   <= day[DAY_W-1:0];
      status    <= st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/tb_gregorian_date_day_arithmetic.sv */
// ----------------------------------------------------------------------------
// tb_gregorian_date_day_arithmetic
// Self-checking bench for next-day, add-days and subtract-days on Gregorian
// dates. A behavioral calendar model predicts each result at acceptance.
// Directed edge dates, a sweep of min_year settings and mostly well-formed
// random dates are sent with random sender gaps. Each done pulse is compared
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gregorian_date_day_arithmetic;
  import gdda_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 200;

  typedef struct packed {
    cmd_t               op;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [COUNT_W-1:0] count;
  } date_request_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    status_t            status;
  } date_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [YEAR_W-1:0]  cfg_wr_data = '0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         cmd = CMD_NEXT;
  logic [YEAR_W-1:0]  in_year = '0;
  logic [MONTH_W-1:0] in_month = '0;
  logic [DAY_W-1:0]   in_day = '0;
  logic [COUNT_W-1:0] day_count = '0;
  logic               done;
  logic [YEAR_W-1:0]  out_year;
  logic [MONTH_W-1:0] out_month;
  logic [DAY_W-1:0]   out_day;
  logic [1:0]         status;

  logic [YEAR_W-1:0]  min_year_cfg = MIN_YEAR_RESET;
  date_result_t       pending_dates[$];
  int                 error_count = 0;
  int                 cycle_count = 0;

  gregorian_date_day_arithmetic DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .in_year    (in_year),
    .in_month   (in_month),
    .in_day     (in_day),
    .day_count  (day_count),
    .done       (done),
    .out_year   (out_year),
    .out_month  (out_month),
    .out_day    (out_day),
    .status     (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("gregorian_date_day_arithmetic: mismatch");
      $finish;
    end
  end

  function automatic bit leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_length(int m, int y);
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic date_result_t shifted_date(date_request_t r);
    date_result_t res;
    int y, m, d, n, lo;
    y  = int'(r.year);
    m  = int'(r.month);
    d  = int'(r.day);
    n  = int'(r.count);
    lo = int'(min_year_cfg);
    res.status = ST_OK;
    if (y < lo || m < 1 || m > 12 || d < 1 || d > month_length(m, y)) begin
      res.status = ST_INVALID;
    end else if (r.op == CMD_NEXT || r.op == CMD_ADD) begin
      if (r.op == CMD_NEXT) n = 1;
      d = d + n;
      while (d > month_length(m, y)) begin
        d = d - month_length(m, y);
        m = m + 1;
        if (m > 12) begin
          m = 1;
          if (y >= 16383) begin
            y = 16383;
            m = 12;
            d = 31;
            res.status = ST_SAT;
            break;
          end
          y = y + 1;
        end
      end
    end else if (r.op == CMD_SUB) begin
      d = d - n;
      while (d < 1) begin
        m = m - 1;
        if (m == 0) begin
          if (y <= lo) begin
            y = lo;
            m = 1;
            d = 1;
            res.status = ST_SAT;
            break;
          end
          m = 12;
          y = y - 1;
        end
        d = d + month_length(m, y);
      end
    end
    res.year  = y[YEAR_W-1:0];
    res.month = m[MONTH_W-1:0];
    res.day   = d[DAY_W-1:0];
    return res;
  endfunction

  function automatic date_request_t date_req(cmd_t op, int y, int m, int d, int n);
    date_request_t r;
    r.op    = op;
    r.year  = y[YEAR_W-1:0];
    r.month = m[MONTH_W-1:0];
    r.day   = d[DAY_W-1:0];
    r.count = n[COUNT_W-1:0];
    return r;
  endfunction

  function automatic date_request_t random_request();
    date_request_t r;
    int lo, pick, y, m, d, len, n;
    lo   = int'(min_year_cfg);
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      r.op    = cmd_t'($urandom_range(0, 3));
      r.year  = YEAR_W'($urandom);
      r.month = MONTH_W'($urandom);
      r.day   = DAY_W'($urandom);
      r.count = COUNT_W'($urandom);
      return r;
    end
    pick = $urandom_range(0, 99);
    if (pick < 25) y = lo + $urandom_range(0, 3);
    else if (pick < 50) y = 16383 - $urandom_range(0, 3);
    else y = $urandom_range(lo, 16383);
    if (y > 16383) y = 16383;
    if (y < lo) y = lo;
    m    = $urandom_range(1, 12);
    len  = month_length(m, y);
    pick = $urandom_range(0, 99);
    if (pick < 15) d = len;
    else if (pick < 25) d = 1;
    else d = $urandom_range(1, len);
    pick = $urandom_range(0, 99);
    if (pick < 60) n = $urandom_range(0, 60);
    else if (pick < 85) n = $urandom_range(61, 1500);
    else if (pick < 95) n = $urandom_range(1501, 20000);
    else n = $urandom_range(20001, 65535);
    r = date_req(($urandom_range(0, 99) < 3) ? CMD_NOP : cmd_t'($urandom_range(0, 2)),
                 y, m, d, n);
    return r;
  endfunction

  task automatic note_error(string msg);
    error_count++;
    if (error_count <= 10) $display("bad result at cycle %0d: %s", cycle_count, msg);
  endtask

  always @(posedge clk) begin : result_check
    date_result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_dates.size() == 0) begin
        note_error($sformatf("unexpected %0d-%0d-%0d status %0d",
                             out_year, out_month, out_day, status));
      end else begin
        want = pending_dates.pop_front();
        if (out_year !== want.year || out_month !== want.month ||
            out_day !== want.day || status !== want.status) begin
          note_error($sformatf("exp %0d-%0d-%0d status %0d, got %0d-%0d-%0d status %0d",
                               want.year, want.month, want.day, want.status,
                               out_year, out_month, out_day, status));
        end
      end
    end
  end

  task automatic send_request(date_request_t r);
    cmd       <= r.op;
    in_year   <= r.year;
    in_month  <= r.month;
    in_day    <= r.day;
    day_count <= r.count;
    start     <= 1'b1;
    do @(posedge clk); while (busy);
    pending_dates.push_back(shifted_date(r));
  endtask

  task automatic idle_gap(bit allow);
    int pick, n;
    n = 0;
    if (allow) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) n = 0;
      else if (pick < 85) n = $urandom_range(1, 3);
      else if (pick < 96) n = $urandom_range(4, 20);
      else n = $urandom_range(30, 150);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_dates.size() != 0);
  endtask

  task automatic write_min_year(int value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[YEAR_W-1:0];
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    min_year_cfg = value[YEAR_W-1:0];
  endtask

  task automatic test_directed_dates();
    date_request_t list[$];
    list.push_back(date_req(CMD_NEXT, 2023, 6, 15, 0));
    list.push_back(date_req(CMD_NEXT, 2023, 1, 31, 0));
    list.push_back(date_req(CMD_NEXT, 2023, 12, 31, 0));
    list.push_back(date_req(CMD_NEXT, 2024, 2, 28, 0));
    list.push_back(date_req(CMD_NEXT, 2024, 2, 29, 0));
    list.push_back(date_req(CMD_NEXT, 1900, 2, 28, 0));
    list.push_back(date_req(CMD_NEXT, 2000, 2, 28, 0));
    list.push_back(date_req(CMD_NEXT, 16383, 12, 31, 0));
    list.push_back(date_req(CMD_ADD, 2023, 5, 10, 0));
    list.push_back(date_req(CMD_SUB, 2023, 5, 10, 0));
    list.push_back(date_req(CMD_ADD, 1601, 1, 1, 65535));
    list.push_back(date_req(CMD_SUB, 16383, 12, 31, 65535));
    list.push_back(date_req(CMD_ADD, 16383, 1, 1, 65535));
    list.push_back(date_req(CMD_SUB, 1601, 1, 1, 1));
    list.push_back(date_req(CMD_SUB, 1601, 3, 1, 1));
    list.push_back(date_req(CMD_SUB, 2024, 3, 1, 1));
    list.push_back(date_req(CMD_SUB, 16383, 5, 31, 40000));
    list.push_back(date_req(CMD_ADD, 2023, 0, 10, 5));
    list.push_back(date_req(CMD_ADD, 2023, 13, 10, 5));
    list.push_back(date_req(CMD_SUB, 2023, 15, 31, 5));
    list.push_back(date_req(CMD_NEXT, 2023, 7, 0, 0));
    list.push_back(date_req(CMD_NEXT, 2023, 4, 31, 0));
    list.push_back(date_req(CMD_NEXT, 2023, 2, 29, 0));
    list.push_back(date_req(CMD_ADD, 1600, 6, 1, 10));
    list.push_back(date_req(CMD_SUB, 0, 15, 31, 65535));
    list.push_back(date_req(CMD_NOP, 2023, 7, 4, 100));
    list.push_back(date_req(CMD_NOP, 2023, 2, 30, 100));
    foreach (list[i]) begin
      send_request(list[i]);
      idle_gap(1'b1);
    end
  endtask

  task automatic test_min_year_settings();
    int settings[$];
    int lo;
    settings = '{1, 16383, 0, 0, 0, 1601};
    settings[3] = $urandom_range(1, 4000);
    settings[4] = $urandom_range(1, 16383);
    foreach (settings[i]) begin
      lo = settings[i];
      write_min_year(lo);
      send_request(date_req(CMD_SUB, lo, 1, 1, 1));
      idle_gap(1'b1);
      send_request(date_req(CMD_ADD, lo, 3, 1, 400));
      idle_gap(1'b1);
      if (lo > 0) send_request(date_req(CMD_NEXT, lo - 1, 6, 15, 0));
      else send_request(date_req(CMD_NEXT, 0, 2, 28, 0));
      idle_gap(1'b1);
      repeat (4) begin
        send_request(random_request());
        idle_gap(1'b1);
      end
    end
  endtask

  task automatic test_random_dates();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain_results();
      send_request(random_request());
      idle_gap(((i / 25) % 3) != 1);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_dates();
    test_min_year_settings();
    test_random_dates();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("gregorian_date_day_arithmetic: match");
    end else begin
      $display("gregorian_date_day_arithmetic: mismatch");
    end
    $finish;
  end

endmodule
